// ----- hdl/memq_pkg.sv -----
package memq_pkg;

  localparam int ENDPOINT_SLOTS = 128;
  localparam int QUEUE_DEPTH    = 64;
  localparam int LENGTH_BITS    = 12;

  localparam int SLOT_BITS = (ENDPOINT_SLOTS > 1) ? $clog2(ENDPOINT_SLOTS) : 1;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W   = 2;
  localparam int ID_W   = 32;
  localparam int PAY_W  = 64;
  localparam int LEN_W  = 12;
  localparam int STAT_W = 3;

  localparam logic [LEN_W-1:0] LEN_MASK = (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} :
                                          LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_SEND    = 2'd2;
  localparam logic [OP_W-1:0] OP_RECV    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] cap;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   new_id;
    logic [PAY_W-1:0]  payload;
    logic [LEN_W-1:0]  dlen;
    logic [LEN_W-1:0]  clen;
  } res_t;

  typedef struct packed {
    logic [QPTR_BITS-1:0] head;
    logic [QPTR_BITS-1:0] tail;
    logic [QCNT_BITS-1:0] count;
  } ptr_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_hs_t;

endpackage

// ----- hdl/memq_front.sv -----
module memq_front
  import memq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_take
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = entry[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= in_item;
  end

endmodule

// ----- hdl/memq_back.sv -----
module memq_back
  import memq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_take,
  output res_hs_t res_out,
  input  logic    res_take
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENC  = 3'd1;
  localparam logic [2:0] S_PTR  = 3'd2;
  localparam logic [2:0] S_MSG  = 3'd3;

  localparam int MSG_AW = SLOT_BITS + QPTR_BITS;

  logic [2:0] state, state_next;
  item_t      cur;
  logic [ENDPOINT_SLOTS-1:0] slot_active;
  logic [ID_W-1:0]           slot_id [ENDPOINT_SLOTS];
  logic [ENDPOINT_SLOTS-1:0] sel_vec;
  logic [ID_W-1:0]           next_id;
  logic [SLOT_BITS-1:0]      slot_idx;
  logic                      found;
  logic [SLOT_BITS-1:0]      enc_idx;
  logic                      enc_any;

  ptr_t ptr_mem [ENDPOINT_SLOTS];
  ptr_t ptr_rd;
  logic [PAY_W+LEN_W-1:0] msg_mem [2**MSG_AW];
  logic [PAY_W+LEN_W-1:0] msg_rd;

  logic res_pend;
  res_t res;
  logic res_free;

  logic                   fin;
  res_t                   res_next;
  logic                   ptr_we;
  ptr_t                   ptr_wdata;
  logic                   msg_we;
  logic                   act_set, act_clr;
  logic [MSG_AW-1:0]      msg_raddr;
  logic [MSG_AW-1:0]      msg_waddr;
  logic [LEN_W-1:0]       rd_len;
  logic [LEN_W-1:0]       rd_copy;

  assign res_free        = !res_pend || res_take;
  assign res_out.valid   = res_pend;
  assign res_out.res     = res;
  assign q_take          = (state == S_IDLE) && q_valid;
  assign msg_raddr       = {slot_idx, ptr_rd.head};
  assign msg_waddr       = {slot_idx, ptr_rd.tail};
  assign rd_len          = msg_rd[LEN_W-1:0] & LEN_MASK;
  assign rd_copy         = (rd_len < cur.cap) ? rd_len : cur.cap;

  // lowest set bit wins
  always_comb begin
    enc_idx = '0;
    enc_any = 1'b0;
    for (int i = ENDPOINT_SLOTS - 1; i >= 0; i--) begin
      if (sel_vec[i]) begin
        enc_idx = SLOT_BITS'(i);
        enc_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    fin        = 1'b0;
    res_next   = '0;
    ptr_we     = 1'b0;
    ptr_wdata  = '0;
    msg_we     = 1'b0;
    act_set    = 1'b0;
    act_clr    = 1'b0;
    case (state)
      S_IDLE: if (q_valid) state_next = S_ENC;
      S_ENC:  state_next = S_PTR;
      S_PTR: begin
        if (!found) begin
          res_next.status = (cur.op == OP_CREATE) ? ST_NO_SLOT : ST_NOT_FOUND;
          fin = res_free;
        end else begin
          case (cur.op)
            OP_CREATE: begin
              fin             = res_free;
              res_next.new_id = next_id;
              act_set         = fin;
              ptr_we          = fin;
            end
            OP_DESTROY: begin
              fin     = res_free;
              act_clr = fin;
              ptr_we  = fin;
            end
            OP_SEND: begin
              fin = res_free;
              if (ptr_rd.count >= QCNT_BITS'(QUEUE_DEPTH)) begin
                res_next.status = ST_FULL;
              end else begin
                msg_we          = fin;
                ptr_we          = fin;
                ptr_wdata.head  = ptr_rd.head;
                ptr_wdata.tail  = (ptr_rd.tail == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                                  ptr_rd.tail + 1'b1;
                ptr_wdata.count = ptr_rd.count + 1'b1;
              end
            end
            default: begin
              if (ptr_rd.count == '0) begin
                res_next.status = ST_EMPTY;
                fin = res_free;
              end else begin
                state_next = S_MSG;
              end
            end
          endcase
        end
        if (fin) state_next = S_IDLE;
      end
      S_MSG: begin
        fin              = res_free;
        res_next.dlen    = rd_len;
        res_next.clen    = rd_copy;
        res_next.payload = (rd_copy != '0) ? msg_rd[PAY_W+LEN_W-1:LEN_W] : '0;
        ptr_we           = fin;
        ptr_wdata.head   = (ptr_rd.head == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                           ptr_rd.head + 1'b1;
        ptr_wdata.tail   = ptr_rd.tail;
        ptr_wdata.count  = ptr_rd.count - 1'b1;
        if (fin) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_active <= '0;
      next_id     <= ID_W'(1);
      res_pend    <= 1'b0;
    end else begin
      state <= state_next;
      if (act_set) begin
        slot_active[slot_idx] <= 1'b1;
        next_id               <= next_id + 1'b1;
      end
      if (act_clr) slot_active[slot_idx] <= 1'b0;
      if (fin) res_pend <= 1'b1;
      else if (res_take) res_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENDPOINT_SLOTS; i++) slot_id[i] <= '0;
    end else if (act_set) begin
      slot_id[slot_idx] <= next_id;
    end else if (act_clr) begin
      slot_id[slot_idx] <= '0;
    end
  end

  // parallel id match, registered before the encoder
  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_item;
      for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
        sel_vec[i] <= (q_item.op == OP_CREATE) ? !slot_active[i] :
                      (slot_active[i] && (slot_id[i] == q_item.id));
      end
    end
    if (state == S_ENC) begin
      slot_idx <= enc_idx;
      found    <= enc_any;
    end
    if (fin) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[slot_idx] <= ptr_wdata;
    ptr_rd <= ptr_mem[enc_idx];
  end

  always_ff @(posedge clk) begin
    if (msg_we) msg_mem[msg_waddr] <= {cur.payload, cur.len & LEN_MASK};
    msg_rd <= msg_mem[msg_raddr];
  end

endmodule

// ----- hdl/multi_endpoint_message_queue.sv -----
// Mailbox engine: up to ENDPOINT_SLOTS endpoints, each with a FIFO of QUEUE_DEPTH
// messages. Every input beat gives exactly one result beat. An accepted item waits in
// a two-entry input queue; the sequencer then runs it through id match, priority encode
// plus pointer memory read, and pointer update; a receive that finds a message adds the
// message memory read. Items are handled one at a time.
// No clearing pass follows reset; the block takes items right away.
module multi_endpoint_message_queue
  import memq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [ID_W-1:0]      endpoint_id,
  input  logic [PAY_W-1:0]     send_payload,
  input  logic [LEN_W-1:0]     send_length,
  input  logic [LEN_W-1:0]     receive_capacity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    result_status,
  output logic [ID_W-1:0]      new_endpoint_id,
  output logic [PAY_W-1:0]     delivered_payload,
  output logic [LEN_W-1:0]     delivered_length,
  output logic [LEN_W-1:0]     copied_length
);

  item_t   in_item;
  logic    q_valid;
  item_t   q_item;
  logic    q_take;
  res_hs_t res_hs;
  logic    res_take;

  assign in_item.op      = operation;
  assign in_item.id      = endpoint_id;
  assign in_item.payload = send_payload;
  assign in_item.len     = send_length;
  assign in_item.cap     = receive_capacity;

  memq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  memq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take),
    .res_out  (res_hs),
    .res_take (res_take)
  );

  assign res_take = res_hs.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result_status     <= res_hs.res.status;
      new_endpoint_id   <= res_hs.res.new_id;
      delivered_payload <= res_hs.res.payload;
      delivered_length  <= res_hs.res.dlen;
      copied_length     <= res_hs.res.clen;
    end
  end

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status != ST_OK |->
      new_endpoint_id == '0 && delivered_payload == '0 && copied_length == '0)
    else $error("error result carries data");

  a_copy_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> copied_length <= delivered_length)
    else $error("copied length exceeds message length");

  a_full_front: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule
